// ===== src/dcps_pkg.sv =====
// Package for the DAG critical-path slack block: request and result types,
// operation codes, field widths and the vertex index reduction.
// Depends on nothing; every other file but dcps_ram imports it.
`timescale 1ns / 1ps
`default_nettype none

package dcps_pkg;

    localparam int VERTEX_W             = 10;
    localparam int WEIGHT_W             = 16;
    localparam int COST_W               = 32;
    localparam int OP_W                 = 2;
    localparam int NUM_VERTICES_DEFAULT = 1024;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    localparam logic [OP_W-1:0] OP_BEGIN = 2'd0;
    localparam logic [OP_W-1:0] OP_FWD   = 2'd1;
    localparam logic [OP_W-1:0] OP_BWD   = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [VERTEX_W-1:0] vertex;
        logic [VERTEX_W-1:0] neighbor;
        logic [WEIGHT_W-1:0] weight;
        logic                has_edge;
        logic                last_edge;
    } in_item_t;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex_out;
        logic [COST_W-1:0]   cost;
        logic [COST_W-1:0]   slack;
        logic [COST_W-1:0]   span;
        logic [VERTEX_W-1:0] critical_vertex;
        logic                critical_valid;
        logic                saturated;
    } result_t;

    // Reduces a vertex index modulo the table depth by restoring subtraction.
    function automatic logic [VERTEX_W-1:0] vmod(input logic [VERTEX_W-1:0] x,
                                                 input int unsigned n);
        int unsigned r;
        r = 32'(x);
        for (int k = VERTEX_W - 1; k >= 0; k--) begin
            if (r >= (n << k)) begin
                r = r - (n << k);
            end
        end
        return r[VERTEX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/dcps_ram.sv =====
// Single-port-write, single-port-read synchronous table memory with a
// registered read. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module dcps_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/dcps_engine.sv =====
// Edge engine: table reads, operand forwarding, saturating arithmetic and the
// per-vertex accumulators, with write-back of start, time-to-end and slack.
// Depends on dcps_pkg and dcps_ram.
`timescale 1ns / 1ps
`default_nettype none

module dcps_engine import dcps_pkg::*; #(
    parameter int NUM_VERTICES = NUM_VERTICES_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     in_valid,
    input  in_item_t in_item,
    output logic     res_valid,
    output result_t  res
);

    localparam int AW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;

    logic [AW-1:0] vi_in, ni_in;
    logic          acc;

    logic [COST_W-1:0] rd_start_n, rd_start_v, rd_to_end, rd_slack;

    logic              wr_start, wr_back;
    logic [COST_W-1:0] cost_w, slack_w;

    logic          s1_valid_reg;
    in_item_t      s1_item_reg;
    logic [AW-1:0] s1_vi_reg, s1_ni_reg;

    logic              hs_valid_reg, hb_valid_reg;
    logic [AW-1:0]     hs_addr_reg, hb_addr_reg;
    logic [COST_W-1:0] hs_data_reg, hb_to_end_reg, hb_slack_reg;

    logic [COST_W-1:0] start_ni_f, start_vi_f, to_end_f, slack_f;
    logic [COST_W:0]   sum_a, sum_sa, sum_p;

    logic                s2_valid_reg, s2_has_reg, s2_last_reg;
    logic [OP_W-1:0]     s2_op_reg;
    logic [VERTEX_W-1:0] s2_vertex_reg;
    logic [AW-1:0]       s2_vi_reg;
    logic [COST_W-1:0]   a_val_reg, sa_val_reg, start_ni_reg, start_vi_reg, slack_ni_reg;
    logic                a_sat_reg, sa_sat_reg;
    logic [COST_W:0]     p_reg;

    logic [COST_W-1:0]   edge_max_reg, edge_min_reg, fspan_reg, bspan_reg;
    logic [COST_W-1:0]   edge_max_next, edge_min_next, fspan_next, bspan_next;
    logic                edge_seen_reg, span_valid_reg, sat_reg;
    logic                edge_seen_next, span_valid_next, sat_next;
    logic [VERTEX_W-1:0] span_vertex_reg, span_vertex_next;

    logic              arc_pos, s_sat, seen_new, s2_go, s2_clear;
    logic [COST_W:0]   diff;
    logic [COST_W-1:0] s_val, max_new, min_new, sink_slack;

    assign acc   = in_valid & en;
    assign vi_in = AW'(vmod(in_item.vertex, NUM_VERTICES));
    assign ni_in = AW'(vmod(in_item.neighbor, NUM_VERTICES));

    dcps_ram #(.DEPTH(NUM_VERTICES), .AW(AW), .DW(COST_W)) u_start_nbr (
        .clk(clk), .re(en), .raddr(ni_in), .rdata(rd_start_n),
        .we(wr_start), .waddr(s2_vi_reg), .wdata(cost_w)
    );

    dcps_ram #(.DEPTH(NUM_VERTICES), .AW(AW), .DW(COST_W)) u_start_vtx (
        .clk(clk), .re(en), .raddr(vi_in), .rdata(rd_start_v),
        .we(wr_start), .waddr(s2_vi_reg), .wdata(cost_w)
    );

    dcps_ram #(.DEPTH(NUM_VERTICES), .AW(AW), .DW(COST_W)) u_to_end (
        .clk(clk), .re(en), .raddr(ni_in), .rdata(rd_to_end),
        .we(wr_back), .waddr(s2_vi_reg), .wdata(cost_w)
    );

    dcps_ram #(.DEPTH(NUM_VERTICES), .AW(AW), .DW(COST_W)) u_slack (
        .clk(clk), .re(en), .raddr(ni_in), .rdata(rd_slack),
        .we(wr_back), .waddr(s2_vi_reg), .wdata(slack_w)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            hs_valid_reg <= 1'b0;
            hb_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= acc;
            hs_valid_reg <= wr_start;
            hb_valid_reg <= wr_back;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_item_reg   <= in_item;
            s1_vi_reg     <= vi_in;
            s1_ni_reg     <= ni_in;
            hs_addr_reg   <= s2_vi_reg;
            hs_data_reg   <= cost_w;
            hb_addr_reg   <= s2_vi_reg;
            hb_to_end_reg <= cost_w;
            hb_slack_reg  <= slack_w;
        end
    end

    // The write under way in the second stage takes priority over the one
    // held from the previous cycle, which the memory read has not yet seen.
    always_comb
    begin
        start_ni_f = rd_start_n;
        if (wr_start && (s2_vi_reg == s1_ni_reg))
        begin
            start_ni_f = cost_w;
        end
        else if (hs_valid_reg && (hs_addr_reg == s1_ni_reg))
        begin
            start_ni_f = hs_data_reg;
        end

        start_vi_f = rd_start_v;
        if (wr_start && (s2_vi_reg == s1_vi_reg))
        begin
            start_vi_f = cost_w;
        end
        else if (hs_valid_reg && (hs_addr_reg == s1_vi_reg))
        begin
            start_vi_f = hs_data_reg;
        end

        to_end_f = rd_to_end;
        slack_f  = rd_slack;
        if (wr_back && (s2_vi_reg == s1_ni_reg))
        begin
            to_end_f = cost_w;
            slack_f  = slack_w;
        end
        else if (hb_valid_reg && (hb_addr_reg == s1_ni_reg))
        begin
            to_end_f = hb_to_end_reg;
            slack_f  = hb_slack_reg;
        end
    end

    always_comb
    begin
        sum_a  = {1'b0, (s1_item_reg.operation == OP_FWD) ? start_ni_f : to_end_f}
               + (COST_W + 1)'(s1_item_reg.weight);
        sum_sa = {1'b0, start_vi_f} + (COST_W + 1)'(s1_item_reg.weight);
        sum_p  = {1'b0, start_ni_f} + {1'b0, slack_f};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_op_reg     <= s1_item_reg.operation;
            s2_vertex_reg <= s1_item_reg.vertex;
            s2_has_reg    <= s1_item_reg.has_edge;
            s2_last_reg   <= s1_item_reg.last_edge;
            s2_vi_reg     <= s1_vi_reg;
            a_sat_reg     <= sum_a[COST_W];
            a_val_reg     <= sum_a[COST_W] ? COST_MAX : sum_a[COST_W-1:0];
            sa_sat_reg    <= sum_sa[COST_W];
            sa_val_reg    <= sum_sa[COST_W] ? COST_MAX : sum_sa[COST_W-1:0];
            p_reg         <= sum_p;
            start_ni_reg  <= start_ni_f;
            start_vi_reg  <= start_vi_f;
            slack_ni_reg  <= slack_f;
        end
    end

    always_comb
    begin
        arc_pos    = start_ni_reg > sa_val_reg;
        diff       = p_reg - {1'b0, sa_val_reg};
        s_sat      = arc_pos && diff[COST_W];
        s_val      = !arc_pos ? slack_ni_reg : (s_sat ? COST_MAX : diff[COST_W-1:0]);
        max_new    = (s2_has_reg && (a_val_reg > edge_max_reg)) ? a_val_reg : edge_max_reg;
        min_new    = (s2_has_reg && (s_val < edge_min_reg)) ? s_val : edge_min_reg;
        seen_new   = edge_seen_reg | s2_has_reg;
        sink_slack = (fspan_reg > start_vi_reg) ? (fspan_reg - start_vi_reg) : '0;
        s2_go      = en && s2_valid_reg;
        s2_clear   = s2_go && (s2_op_reg == OP_BEGIN);

        edge_max_next    = edge_max_reg;
        edge_min_next    = edge_min_reg;
        edge_seen_next   = edge_seen_reg;
        fspan_next       = fspan_reg;
        bspan_next       = bspan_reg;
        span_vertex_next = span_vertex_reg;
        span_valid_next  = span_valid_reg;
        sat_next         = sat_reg;
        wr_start         = 1'b0;
        wr_back          = 1'b0;
        cost_w           = '0;
        slack_w          = '0;
        res_valid        = 1'b0;

        if (s2_go)
        begin
            unique case (s2_op_reg)
                OP_BEGIN:
                begin
                    edge_max_next    = '0;
                    edge_min_next    = COST_MAX;
                    edge_seen_next   = 1'b0;
                    fspan_next       = '0;
                    bspan_next       = '0;
                    span_vertex_next = '0;
                    span_valid_next  = 1'b0;
                    sat_next         = 1'b0;
                end
                OP_FWD:
                begin
                    sat_next       = sat_reg | (s2_has_reg & a_sat_reg);
                    edge_max_next  = max_new;
                    edge_seen_next = seen_new;
                    if (s2_last_reg)
                    begin
                        cost_w    = max_new;
                        wr_start  = 1'b1;
                        res_valid = 1'b1;
                        if (max_new > fspan_reg)
                        begin
                            fspan_next       = max_new;
                            span_vertex_next = s2_vertex_reg;
                            span_valid_next  = 1'b1;
                        end
                        edge_max_next  = '0;
                        edge_min_next  = COST_MAX;
                        edge_seen_next = 1'b0;
                    end
                end
                OP_BWD:
                begin
                    sat_next       = sat_reg
                                   | (s2_has_reg & (a_sat_reg | sa_sat_reg | s_sat));
                    edge_max_next  = max_new;
                    edge_min_next  = min_new;
                    edge_seen_next = seen_new;
                    if (s2_last_reg)
                    begin
                        cost_w    = seen_new ? max_new : '0;
                        slack_w   = seen_new ? min_new : sink_slack;
                        wr_back   = 1'b1;
                        res_valid = 1'b1;
                        if (cost_w > bspan_reg)
                        begin
                            bspan_next = cost_w;
                        end
                        edge_max_next  = '0;
                        edge_min_next  = COST_MAX;
                        edge_seen_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        res.vertex_out      = s2_vertex_reg;
        res.cost            = cost_w;
        res.slack           = slack_w;
        res.span            = (s2_op_reg == OP_FWD) ? fspan_next : bspan_next;
        res.critical_vertex = span_vertex_next;
        res.critical_valid  = span_valid_next;
        res.saturated       = sat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_max_reg    <= '0;
            edge_min_reg    <= COST_MAX;
            edge_seen_reg   <= 1'b0;
            fspan_reg       <= '0;
            bspan_reg       <= '0;
            span_vertex_reg <= '0;
            span_valid_reg  <= 1'b0;
            sat_reg         <= 1'b0;
        end
        else
        begin
            edge_max_reg    <= edge_max_next;
            edge_min_reg    <= edge_min_next;
            edge_seen_reg   <= edge_seen_next;
            fspan_reg       <= fspan_next;
            bspan_reg       <= bspan_next;
            span_vertex_reg <= span_vertex_next;
            span_valid_reg  <= span_valid_next;
            sat_reg         <= sat_next;
        end
    end

    // The forward makespan only grows between two begin requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s2_clear |=> fspan_reg >= $past(fspan_reg))
        else $error("forward makespan decreased without a begin request");

    // A critical vertex is only recorded once the makespan is nonzero.
    assert property (@(posedge clk) disable iff (!rst_n)
        span_valid_reg |-> fspan_reg != '0)
        else $error("critical vertex valid with a zero makespan");

    // A stalled pipeline neither loses nor invents a request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> (s1_valid_reg == $past(s1_valid_reg)) && (s2_valid_reg == $past(s2_valid_reg)))
        else $error("pipeline advanced while stalled");

endmodule

`default_nettype wire

// ===== src/dcps_out_fifo.sv =====
// Two-entry result queue between the edge engine and the output stream,
// so that requests keep flowing while a result waits. Depends on dcps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcps_out_fifo import dcps_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    result_t     entry_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg, count_next;
    logic        pop;

    assign pop     = m_valid & m_ready;
    assign m_valid = count_reg != 2'd0;
    assign full    = count_reg == 2'd2;
    assign m_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != 2'd2)
        else $error("result pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> count_reg == $past(count_reg) - 2'd1)
        else $error("queue count did not drop after a pop");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("queue holds more than two results");

endmodule

`default_nettype wire

// ===== src/dag_critical_path_slack.sv =====
// Top level of the DAG critical-path slack block: stream ports, packing of
// the request and result fields, the edge engine and the result queue.
// Depends on dcps_pkg, dcps_engine and dcps_out_fifo.
//
// The host sends a begin request, then one request per in-edge of each
// vertex in topological order, then one per out-edge in reverse order. A
// request with tlast set closes its vertex and yields one result on the
// master side with earliest start or time to end, slack, running makespan,
// critical vertex and a sticky saturation flag.
// A result passes the first and second stage registers and then the output
// queue before it is presented. Throughput is one request per cycle while the
// output queue is not full: each edge does a registered table read and writes
// back from the second stage, and forwarding from the write stage and the last
// write keeps dependent edges at full rate.
// Reset clears the pipeline and the pass accumulators; the start,
// time-to-end and slack tables are not cleared and must be written by the
// pass before they are read. When the receiver stalls, up to two results
// wait in the output queue; once it is full, s_tready falls and the whole
// pipeline holds until a result is taken.
`timescale 1ns / 1ps
`default_nettype none

module dag_critical_path_slack import dcps_pkg::*; #(
    parameter int NUM_VERTICES = NUM_VERTICES_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // vertex, neighbor, weight, zero fill
    input  logic [2:0]   s_tuser,   // operation, has_edge
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [119:0] m_tdata,   // vertex_out, cost, slack, span, critical_vertex, zero fill
    output logic [1:0]   m_tuser    // critical_valid, saturated
);

    in_item_t in_item;
    result_t  res, out_res;
    logic     res_valid, full, en;

    assign en       = ~full;
    assign s_tready = en;

    assign in_item.operation = s_tuser[1:0];
    assign in_item.has_edge  = s_tuser[2];
    assign in_item.vertex    = s_tdata[9:0];
    assign in_item.neighbor  = s_tdata[19:10];
    assign in_item.weight    = s_tdata[35:20];
    assign in_item.last_edge = s_tlast;

    dcps_engine #(.NUM_VERTICES(NUM_VERTICES)) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .in_item  (in_item),
        .res_valid(res_valid),
        .res      (res)
    );

    dcps_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_valid),
        .push_data(res),
        .full     (full),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_data   (out_res)
    );

    assign m_tdata = {4'b0000, out_res.critical_vertex, out_res.span, out_res.slack,
                      out_res.cost, out_res.vertex_out};
    assign m_tuser = {out_res.saturated, out_res.critical_valid};

endmodule

`default_nettype wire

// ===== tb/dcps_checker.sv =====
// Checker for the DAG critical-path slack block: watches both stream channels,
// keeps its own timing tables and pass state, and compares every result.
// Depends on dcps_pkg for the request and result types and operation codes.
`timescale 1ns / 1ps

module dcps_checker import dcps_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [39:0]  s_tdata,
    input  logic [2:0]   s_tuser,
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [119:0] m_tdata,
    input  logic [1:0]   m_tuser,
    output int           errors,
    output int           pending,
    output int           checked
);

    localparam int NV = NUM_VERTICES_DEFAULT;

    logic [COST_W-1:0]   start_tbl [NV];
    logic [COST_W-1:0]   to_end_tbl [NV];
    logic [COST_W-1:0]   slack_tbl [NV];
    logic [COST_W-1:0]   edge_hi;
    logic [COST_W-1:0]   edge_lo;
    logic                edge_hit;
    logic [COST_W-1:0]   fwd_span;
    logic [COST_W-1:0]   bwd_span;
    logic [VERTEX_W-1:0] crit_vtx;
    logic                crit_valid;
    logic                clamped;
    result_t             due_results [$];

    function automatic logic [COST_W-1:0] add_clamped(input logic [COST_W-1:0] a,
                                                      input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[COST_W])
        begin
            clamped = 1'b1;
            return COST_MAX;
        end
        return s[COST_W-1:0];
    endfunction

    function automatic logic [COST_W-1:0] diff_clamped(input logic [COST_W-1:0] a,
                                                       input logic [COST_W-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    function automatic string describe(input result_t r);
        return $sformatf("vertex %0d cost %h slack %h span %h crit %0d valid %b sat %b",
                         r.vertex_out, r.cost, r.slack, r.span, r.critical_vertex,
                         r.critical_valid, r.saturated);
    endfunction

    task automatic clear_edge();
        edge_hi  = '0;
        edge_lo  = COST_MAX;
        edge_hit = 1'b0;
    endtask

    task automatic clear_pass();
        clear_edge();
        fwd_span   = '0;
        bwd_span   = '0;
        crit_vtx   = '0;
        crit_valid = 1'b0;
        clamped    = 1'b0;
    endtask

    task automatic predict_timing(input in_item_t rq);
        int                vi;
        int                ni;
        logic [COST_W-1:0] w;
        logic [COST_W-1:0] t;
        logic [COST_W-1:0] arc;
        logic [COST_W-1:0] s;
        result_t           res;
        vi  = int'(rq.vertex) % NV;
        ni  = int'(rq.neighbor) % NV;
        w   = COST_W'(rq.weight);
        res = '0;
        res.vertex_out = rq.vertex;
        if (rq.operation == OP_BEGIN)
        begin
            clear_pass();
        end
        else if (rq.operation == OP_FWD)
        begin
            if (rq.has_edge)
            begin
                t = add_clamped(start_tbl[ni], w);
                if (t > edge_hi)
                    edge_hi = t;
                edge_hit = 1'b1;
            end
            if (rq.last_edge)
            begin
                res.cost = edge_hi;
                start_tbl[vi] = edge_hi;
                if (edge_hi > fwd_span)
                begin
                    fwd_span   = edge_hi;
                    crit_vtx   = rq.vertex;
                    crit_valid = 1'b1;
                end
                res.span = fwd_span;
            end
        end
        else if (rq.operation == OP_BWD)
        begin
            if (rq.has_edge)
            begin
                t   = add_clamped(to_end_tbl[ni], w);
                arc = diff_clamped(start_tbl[ni], add_clamped(start_tbl[vi], w));
                s   = add_clamped(arc, slack_tbl[ni]);
                if (t > edge_hi)
                    edge_hi = t;
                if (s < edge_lo)
                    edge_lo = s;
                edge_hit = 1'b1;
            end
            if (rq.last_edge)
            begin
                if (edge_hit)
                begin
                    res.cost  = edge_hi;
                    res.slack = edge_lo;
                end
                else
                begin
                    res.cost  = '0;
                    res.slack = diff_clamped(fwd_span, start_tbl[vi]);
                end
                to_end_tbl[vi] = res.cost;
                slack_tbl[vi]  = res.slack;
                if (res.cost > bwd_span)
                    bwd_span = res.cost;
                res.span = bwd_span;
            end
        end
        if (rq.last_edge && (rq.operation == OP_FWD || rq.operation == OP_BWD))
        begin
            res.critical_vertex = crit_vtx;
            res.critical_valid  = crit_valid;
            res.saturated       = clamped;
            due_results.push_back(res);
            clear_edge();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        in_item_t rq;
        result_t  got;
        result_t  want;
        if (!rst_n)
        begin
            clear_pass();
            due_results.delete();
            pending = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                rq.operation = s_tuser[1:0];
                rq.has_edge  = s_tuser[2];
                rq.vertex    = s_tdata[9:0];
                rq.neighbor  = s_tdata[19:10];
                rq.weight    = s_tdata[35:20];
                rq.last_edge = s_tlast;
                predict_timing(rq);
            end
            if (m_tvalid && m_tready)
            begin
                got.vertex_out      = m_tdata[9:0];
                got.cost            = m_tdata[41:10];
                got.slack           = m_tdata[73:42];
                got.span            = m_tdata[105:74];
                got.critical_vertex = m_tdata[115:106];
                got.critical_valid  = m_tuser[0];
                got.saturated       = m_tuser[1];
                checked++;
                if (due_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result with nothing outstanding: %s", $realtime,
                                 describe(got));
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.vertex_out !== want.vertex_out || got.cost !== want.cost ||
                        got.slack !== want.slack || got.span !== want.span ||
                        got.critical_vertex !== want.critical_vertex ||
                        got.critical_valid !== want.critical_valid ||
                        got.saturated !== want.saturated)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%0t: mismatch, expected %s", $realtime, describe(want));
                            $display("%0t:           actual   %s", $realtime, describe(got));
                        end
                    end
                end
            end
            pending = due_results.size();
        end
    end

endmodule

// ===== tb/dag_critical_path_slack_test.sv =====
// Top of the DAG critical-path slack testbench: clock, reset, request stimulus
// with bursty sending and a stalling receiver, a watchdog and the verdict.
// Depends on dcps_pkg, dag_critical_path_slack and dcps_checker.
`timescale 1ns / 1ps

module dag_critical_path_slack_test;
    import dcps_pkg::*;

    localparam int RANDOM_REQUESTS = 560;
    localparam int RAMP_STEPS      = 24;
    localparam int STALL_LIMIT     = 4000;

    typedef enum int {RX_STEADY, RX_COIN, RX_RUNS} rx_mode_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [39:0]  s_tdata;
    logic [2:0]   s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;
    logic [1:0]   m_tuser;

    int mismatches;
    int results_due;
    int results_seen;

    int sent_reqs;
    int live_reqs;
    int burst_left;
    int passes_run;
    int stray_runs;
    int quiet_cycles;

    bit                  start_ok [1024];
    bit                  end_ok [1024];
    logic [VERTEX_W-1:0] start_q [$];
    logic [VERTEX_W-1:0] end_q [$];

    rx_mode_t rx_mode;
    int       rx_mode_left;
    int       rx_run;
    bit       rx_low;

    dag_critical_path_slack u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    dcps_checker u_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (mismatches),
        .pending  (results_due),
        .checked  (results_seen)
    );

    always #5 clk = ~clk;

    // The receiver switches between always ready, a coin toss per cycle and
    // runs of stalls, each mode lasting a random stretch.
    always @(negedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode      = rx_mode_t'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(20, 200);
        end
        rx_mode_left--;
        case (rx_mode)
            RX_STEADY: m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            default:
            begin
                if (rx_run == 0)
                begin
                    rx_low = !rx_low;
                    rx_run = rx_low ? $urandom_range(1, 8) : $urandom_range(1, 4);
                end
                rx_run--;
                m_tready <= !rx_low;
            end
        endcase
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no request or result moved for %0d cycles", $realtime, STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [VERTEX_W-1:0] rand_vertex();
        return VERTEX_W'($urandom_range(0, 1023));
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return WEIGHT_W'($urandom_range(1, 16));
            default: return WEIGHT_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic logic [VERTEX_W-1:0] any_started();
        return start_q[$urandom_range(0, start_q.size() - 1)];
    endfunction

    function automatic logic [VERTEX_W-1:0] any_finished();
        return end_q[$urandom_range(0, end_q.size() - 1)];
    endfunction

    // Entered and left at a falling edge; the valid stays high between
    // requests of one burst.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [VERTEX_W-1:0] v,
                                input logic [VERTEX_W-1:0] nb, input logic [WEIGHT_W-1:0] w,
                                input bit has, input bit closing);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            repeat (gap)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, w, nb, v};
        s_tuser  <= {has, op};
        s_tlast  <= closing;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        if (closing && op == OP_FWD && !start_ok[v])
        begin
            start_ok[v] = 1'b1;
            start_q.push_back(v);
        end
        if (closing && op == OP_BWD && !end_ok[v])
        begin
            end_ok[v] = 1'b1;
            end_q.push_back(v);
        end
        sent_reqs++;
        if (op != OP_NONE)
            live_reqs++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (results_due != 0);
        burst_left = 0;
    endtask

    // One well-formed pass: begin, forward over a fresh topological order,
    // then backward over it in reverse.
    task automatic run_pass();
        logic [VERTEX_W-1:0] order [$];
        logic [VERTEX_W-1:0] cand;
        logic [VERTEX_W-1:0] nb;
        int                  n_v;
        int                  k;
        bit                  dup;
        n_v = $urandom_range(2, 10);
        while (order.size() < n_v)
        begin
            cand = rand_vertex();
            dup  = 1'b0;
            foreach (order[j])
                if (order[j] == cand)
                    dup = 1'b1;
            if (!dup)
                order.push_back(cand);
        end
        send_request(OP_BEGIN, rand_vertex(), rand_vertex(), pick_weight(),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        foreach (order[i])
        begin
            k = (i == 0) ? $urandom_range(0, 1) : $urandom_range(0, 3);
            if ($urandom_range(0, 7) == 0)
                send_request(OP_FWD, order[i], rand_vertex(), pick_weight(), 1'b0, 1'b0);
            if (k == 0)
                send_request(OP_FWD, order[i], rand_vertex(), pick_weight(), 1'b0, 1'b1);
            for (int e = 0; e < k; e++)
            begin
                if (i > 0 && $urandom_range(0, 4) != 0)
                    nb = order[$urandom_range(0, i - 1)];
                else
                    nb = any_started();
                send_request(OP_FWD, order[i], nb, pick_weight(), 1'b1, e == k - 1);
            end
        end
        for (int i = n_v - 1; i >= 0; i--)
        begin
            k = (i < n_v - 1) ? $urandom_range(0, 3) : $urandom_range(0, 1);
            if ($urandom_range(0, 7) == 0)
                send_request(OP_BWD, order[i], rand_vertex(), pick_weight(), 1'b0, 1'b0);
            if (k == 0)
                send_request(OP_BWD, order[i], rand_vertex(), pick_weight(), 1'b0, 1'b1);
            for (int e = 0; e < k; e++)
            begin
                if (i < n_v - 1 && $urandom_range(0, 4) != 0)
                    nb = order[$urandom_range(i + 1, n_v - 1)];
                else
                    nb = any_finished();
                send_request(OP_BWD, order[i], nb, pick_weight(), 1'b1, e == k - 1);
            end
        end
        passes_run++;
    endtask

    // Stray traffic: unused codes, lone begins and passes mixed mid-vertex,
    // reading only entries that have already been written.
    task automatic run_stray();
        int n;
        n = $urandom_range(1, 3);
        case ($urandom_range(0, 3))
            0:
                repeat (n)
                    send_request(OP_NONE, rand_vertex(), rand_vertex(), pick_weight(),
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            1:
                send_request(OP_BEGIN, rand_vertex(), rand_vertex(), pick_weight(),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            2:
            begin
                repeat (n)
                    send_request(OP_FWD, any_started(), any_started(), pick_weight(),
                                 1'b1, 1'b0);
                send_request(OP_BWD, any_started(), rand_vertex(), pick_weight(), 1'b0, 1'b1);
            end
            default:
                for (int e = 0; e < n; e++)
                    send_request(OP_BWD, any_started(), any_finished(), pick_weight(),
                                 1'b1, e == n - 1);
        endcase
        stray_runs++;
    endtask

    initial
    begin
        logic [VERTEX_W-1:0] ramp_v;
        int                  live_mark;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        s_tlast  = 1'b0;
        rst_n    = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Sources, a tie on the makespan and a later vertex that beats it.
        send_request(OP_BEGIN, 10'h000, 10'h000, 16'h0000, 1'b0, 1'b0);
        send_request(OP_FWD, 10'h000, 10'h3FF, 16'hFFFF, 1'b0, 1'b1);
        send_request(OP_FWD, 10'h3FF, 10'h000, 16'hFFFF, 1'b1, 1'b1);
        send_request(OP_FWD, 10'h155, 10'h3FF, 16'h0000, 1'b1, 1'b0);
        send_request(OP_FWD, 10'h155, 10'h000, 16'hFFFF, 1'b1, 1'b1);
        send_request(OP_FWD, 10'h2AA, 10'h155, 16'hAAAA, 1'b0, 1'b0);
        send_request(OP_FWD, 10'h2AA, 10'h155, 16'h0001, 1'b1, 1'b1);
        send_request(OP_NONE, 10'h3FF, 10'h3FF, 16'hFFFF, 1'b1, 1'b1);
        send_request(OP_NONE, 10'h000, 10'h000, 16'h0000, 1'b0, 1'b0);
        // Backward pass with a sink, a negative arc slack and a multi-edge vertex.
        send_request(OP_BWD, 10'h2AA, 10'h3FF, 16'h5555, 1'b0, 1'b1);
        send_request(OP_BWD, 10'h155, 10'h2AA, 16'h0001, 1'b1, 1'b1);
        send_request(OP_BWD, 10'h3FF, 10'h155, 16'hFFFF, 1'b1, 1'b0);
        send_request(OP_BWD, 10'h3FF, 10'h2AA, 16'h0000, 1'b1, 1'b1);
        send_request(OP_BWD, 10'h000, 10'h3FF, 16'hFFFF, 1'b1, 1'b1);
        // A sink whose start lies beyond the cleared makespan, then mixed passes.
        send_request(OP_BEGIN, 10'h3FF, 10'h3FF, 16'hFFFF, 1'b1, 1'b1);
        send_request(OP_BWD, 10'h3FF, 10'h000, 16'h0000, 1'b0, 1'b1);
        send_request(OP_FWD, 10'h155, 10'h2AA, 16'h0007, 1'b1, 1'b0);
        send_request(OP_BWD, 10'h155, 10'h2AA, 16'h0003, 1'b1, 1'b1);
        send_request(OP_FWD, 10'h0AA, 10'h3FF, 16'h0000, 1'b0, 1'b1);
        wait_drained();

        // A self-loop climbs by the largest weight on every step.
        ramp_v = rand_vertex();
        send_request(OP_BEGIN, ramp_v, ramp_v, 16'h0000, 1'b0, 1'b0);
        send_request(OP_FWD, ramp_v, ramp_v, 16'h0000, 1'b0, 1'b1);
        repeat (RAMP_STEPS)
            send_request(OP_FWD, ramp_v, ramp_v, 16'hFFFF, 1'b1, 1'b1);
        send_request(OP_BWD, ramp_v, ramp_v, 16'h0000, 1'b0, 1'b1);
        send_request(OP_BWD, ramp_v, ramp_v, 16'hFFFF, 1'b1, 1'b1);

        live_mark = live_reqs;
        while (live_reqs - live_mark < RANDOM_REQUESTS)
        begin
            if ($urandom_range(0, 6) == 0)
                run_stray();
            else
                run_pass();
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end

        s_tvalid <= 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Sent %0d requests (%0d live): %0d random passes, %0d stray sequences,",
                 sent_reqs, live_reqs, passes_run, stray_runs);
        $display("a %0d-step self-loop ramp and a directed set; %0d results checked.",
                 RAMP_STEPS, results_seen);
        if (mismatches == 0 && results_due == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
